>>> src/stoch_pkg.sv
package stoch_pkg;

   // Widths fixed by the price and result formats
   localparam int PRICE_W     = 32;
   localparam int CFG_W       = 7;
   localparam int FRAC_BITS   = 16;
   localparam int FRAC_W      = FRAC_BITS + 1;
   localparam int WINDOW_DEF  = 64;
   localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd14;
   localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'h10000;

   // One ring entry: the high and low of a bar
   typedef struct packed {
      logic [PRICE_W-1:0] high;
      logic [PRICE_W-1:0] low;
   } bar_type;

endpackage

>>> src/stoch_if.sv
interface stoch_req_if;
   logic                           valid;
   logic                           ready;
   logic [stoch_pkg::PRICE_W-1:0]  high_price;
   logic [stoch_pkg::PRICE_W-1:0]  low_price;
   logic [stoch_pkg::PRICE_W-1:0]  close_price;

   modport source (output valid, output high_price, output low_price,
                   output close_price, input ready);
   modport sink   (input valid, input high_price, input low_price,
                   input close_price, output ready);
endinterface

interface stoch_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           result_valid;
   logic [stoch_pkg::FRAC_W-1:0]   stoch_fraction;
   logic                           flat_range;

   modport source (output valid, output result_valid, output stoch_fraction,
                   output flat_range, input ready);
   modport sink   (input valid, input result_valid, input stoch_fraction,
                   input flat_range, output ready);
endinterface

>>> src/stoch_ring.sv
module stoch_ring #(
   parameter int DEPTH = stoch_pkg::WINDOW_DEF
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  stoch_pkg::bar_type        wr_bar,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output stoch_pkg::bar_type        rd_bar
);

   stoch_pkg::bar_type mem [DEPTH];
   stoch_pkg::bar_type rd_bar_ff;

   // Write the incoming bar
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_bar;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_bar_ff <= mem[rd_addr];
      end
   end

   assign rd_bar = rd_bar_ff;

endmodule

>>> src/stoch_div.sv
module stoch_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [stoch_pkg::PRICE_W-1:0]       dividend,
   input  logic [stoch_pkg::PRICE_W-1:0]       divisor,
   output logic                                done,
   output logic [stoch_pkg::FRAC_BITS-1:0]     quotient
);

   localparam int STEPS = stoch_pkg::FRAC_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int W     = stoch_pkg::PRICE_W;

   logic [W:0]       rem_ff, rem_in;
   logic [W-1:0]     den_ff, den_in;
   logic [STEPS-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [W:0]       shifted;
   logic [W:0]       diff;

   // One restoring step a cycle; the dividend stays below the divisor
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      shifted = {rem_ff[W-1:0], 1'b0};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         rem_in = {1'b0, dividend};
         den_in = divisor;
         quo_in = '0;
         cnt_in = CNT_W'(STEPS);
      end else if (cnt_ff != '0) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff;
            quo_in = {quo_ff[STEPS-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[STEPS-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/stochastic_oscillator_unit.sv
// From request transfer to response transfer a bar passes a scan of older ring entries
// (windows 0 and 1 read none), evaluate, the divide, hand-off and the output register.
// A warm-up bar skips scan and divide; a flat or out-of-range bar skips the divide. A new
// bar is taken only once the previous one has been handed to the output register.
// Reset (synchronous, active high) clears pointer, bar count and handshakes
// and sets window_length to 14; ring contents are left as they are.
module stochastic_oscillator_unit #(
   parameter int WINDOW_MAX = stoch_pkg::WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   stoch_req_if.sink                     req_chan,
   stoch_rsp_if.source                   rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [stoch_pkg::CFG_W-1:0]   csr_write_data
);

   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int CNT_W = $clog2(WINDOW_MAX + 2);
   localparam int PW    = stoch_pkg::PRICE_W;
   localparam int FW    = stoch_pkg::FRAC_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_PUT  = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [stoch_pkg::CFG_W-1:0] window_ff, window_in;
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           bars_ff, bars_in;
   logic [LEN_W-1:0]           left_ff, left_in;
   logic                       pending_ff, pending_in;
   logic                       valid_ff, valid_in;
   logic [PW-1:0]              close_ff, close_in;
   logic [PW-1:0]              highest_ff, highest_in;
   logic [PW-1:0]              lowest_ff, lowest_in;
   logic [FW-1:0]              frac_ff, frac_in;
   logic                       flat_ff, flat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_result_ff, rsp_result_in;
   logic [FW-1:0]              rsp_frac_ff, rsp_frac_in;
   logic                       rsp_flat_ff, rsp_flat_in;

   logic                       accept;
   logic [LEN_W-1:0]           len_eff;
   logic [CNT_W-1:0]           bars_next;
   logic                       rd_en;
   logic                       load_rsp;
   logic                       div_start;
   logic                       div_done;
   logic [stoch_pkg::FRAC_BITS-1:0] div_quo;
   stoch_pkg::bar_type         wr_bar;
   stoch_pkg::bar_type         rd_bar;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   // Clamp the window and advance the saturating bar count
   always_comb begin
      if (32'(window_ff) > 32'(WINDOW_MAX)) begin
         len_eff = LEN_W'(WINDOW_MAX);
      end else begin
         len_eff = LEN_W'(window_ff);
      end
      if (32'(bars_ff) < 32'(WINDOW_MAX + 1)) begin
         bars_next = bars_ff + 1'b1;
      end else begin
         bars_next = bars_ff;
      end
   end

   assign wr_bar.high = req_chan.high_price;
   assign wr_bar.low  = req_chan.low_price;

   stoch_ring #(
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_ptr_ff),
      .wr_bar  (wr_bar),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_bar  (rd_bar)
   );

   stoch_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (close_ff - lowest_ff),
      .divisor  (highest_ff - lowest_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Sequencer: write bar, scan older entries, evaluate, divide, hand off
   always_comb begin
      state_in      = state_ff;
      window_in     = window_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      bars_in       = bars_ff;
      left_in       = left_ff;
      pending_in    = 1'b0;
      valid_in      = valid_ff;
      close_in      = close_ff;
      highest_in    = highest_ff;
      lowest_in     = lowest_ff;
      frac_in       = frac_ff;
      flat_in       = flat_ff;
      rd_en         = 1'b0;
      div_start     = 1'b0;
      load_rsp      = 1'b0;

      if (csr_write_enable) begin
         window_in = csr_write_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               close_in   = req_chan.close_price;
               highest_in = req_chan.high_price;
               lowest_in  = req_chan.low_price;
               bars_in    = bars_next;
               valid_in   = (bars_next > CNT_W'(len_eff));
               if (wr_ptr_ff == PTR_W'(WINDOW_MAX - 1)) begin
                  wr_ptr_in = '0;
               end else begin
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end
               if (wr_ptr_ff == '0) begin
                  rd_ptr_in = PTR_W'(WINDOW_MAX - 1);
               end else begin
                  rd_ptr_in = wr_ptr_ff - 1'b1;
               end
               if (len_eff == '0) begin
                  left_in = '0;
               end else begin
                  left_in = len_eff - 1'b1;
               end
               if (bars_next > CNT_W'(len_eff)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         S_SCAN: begin
            // Issue one read a cycle, fold the data that returns
            if (left_ff != '0) begin
               rd_en      = 1'b1;
               pending_in = 1'b1;
               left_in    = left_ff - 1'b1;
               if (rd_ptr_ff == '0) begin
                  rd_ptr_in = PTR_W'(WINDOW_MAX - 1);
               end else begin
                  rd_ptr_in = rd_ptr_ff - 1'b1;
               end
            end
            if (pending_ff) begin
               if (rd_bar.high > highest_ff) begin
                  highest_in = rd_bar.high;
               end
               if (rd_bar.low < lowest_ff) begin
                  lowest_in = rd_bar.low;
               end
            end
            if (left_ff == '0 && !pending_ff) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            frac_in  = '0;
            flat_in  = 1'b0;
            state_in = S_PUT;
            if (!valid_ff) begin
               frac_in = '0;
            end else if (highest_ff <= lowest_ff) begin
               flat_in = 1'b1;
            end else if (close_ff <= lowest_ff) begin
               frac_in = '0;
            end else if (close_ff >= highest_ff) begin
               frac_in = stoch_pkg::FRAC_ONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               frac_in  = {1'b0, div_quo};
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: hold until the response transfers
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_frac_in   = rsp_frac_ff;
      rsp_flat_in   = rsp_flat_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = valid_ff;
         rsp_frac_in   = frac_ff;
         rsp_flat_in   = flat_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= stoch_pkg::WINDOW_RESET;
         wr_ptr_ff    <= '0;
         bars_ff      <= '0;
         left_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         wr_ptr_ff    <= wr_ptr_in;
         bars_ff      <= bars_in;
         left_ff      <= left_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      valid_ff      <= valid_in;
      close_ff      <= close_in;
      highest_ff    <= highest_in;
      lowest_ff     <= lowest_in;
      frac_ff       <= frac_in;
      flat_ff       <= flat_in;
      rsp_result_ff <= rsp_result_in;
      rsp_frac_ff   <= rsp_frac_in;
      rsp_flat_ff   <= rsp_flat_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_valid   = rsp_result_ff;
   assign rsp_chan.stoch_fraction = rsp_frac_ff;
   assign rsp_chan.flat_range     = rsp_flat_ff;

endmodule

>>> src/stoch_checker.sv
module stoch_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_result_valid,
   input  logic [stoch_pkg::FRAC_W-1:0] rsp_stoch_fraction,
   input  logic                        rsp_flat_range
);

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Hold a stalled response
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stoch_fraction)
         && $stable(rsp_flat_range) && $stable(rsp_result_valid))
      else $error("stalled response changed");

   // Flat range forces a zero fraction
   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flat_range |-> rsp_stoch_fraction == '0)
      else $error("flat range with nonzero fraction");

   // Warm-up results carry nothing
   a_warmup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_valid |-> rsp_stoch_fraction == '0 && !rsp_flat_range)
      else $error("warm-up result not cleared");

   // Fraction never exceeds one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stoch_fraction <= stoch_pkg::FRAC_ONE)
      else $error("fraction above one");

endmodule

bind stochastic_oscillator_unit stoch_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_result_valid   (rsp_chan.result_valid),
   .rsp_stoch_fraction (rsp_chan.stoch_fraction),
   .rsp_flat_range     (rsp_chan.flat_range)
);
